[sv/fscc_pkg.sv]
// Shared widths, codes and reset values for the fixed-step catch-up clock.
package fscc_pkg;

  localparam int TIME_W = 32;
  localparam int CATCH_W = 16;
  localparam int DIV_W = TIME_W + 1;
  localparam int DROP_W = 33;
  localparam int PROD_W = CATCH_W + TIME_W;
  localparam int CNT_W = $clog2(DIV_W + 1);
  localparam int CFG_W = 32;
  localparam int OUT_FIELDS_W = CATCH_W + DROP_W + TIME_W;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic CMD_ADVANCE = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic REG_STEP_LENGTH = 1'b0;
  localparam logic REG_MAX_CATCH_UP = 1'b1;

  localparam logic [TIME_W-1:0] STEP_LENGTH_RESET = TIME_W'(1000000);
  localparam logic [CATCH_W-1:0] MAX_CATCH_UP_RESET = CATCH_W'(8);

endpackage

[sv/fscc_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module fscc_div
  import fscc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [TIME_W-1:0] divisor,
  output logic              done,
  output logic [DIV_W-1:0]  quotient,
  output logic [TIME_W-1:0] remainder
);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] quo;
  logic [TIME_W-1:0] rem;
  logic [DIV_W-1:0] shifted;
  logic [DIV_W:0]   diff;
  logic             fits;

  always_comb begin
    shifted = {rem, quo[DIV_W-1]};
    diff = {1'b0, shifted} - {2'b00, divisor};
    fits = !diff[DIV_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(DIV_W);
        quo <= dividend;
        rem <= '0;
      end else if (busy) begin
        rem <= fits ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
        quo <= {quo[DIV_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;
  assign remainder = rem;

endmodule

[sv/fixed_step_catch_up_clock_unit.sv]
// Top level of the fixed-step catch-up clock: command sequencing and result register.
//
// Input items arrive on the s_ channel: tdata carries the elapsed ticks and
// tuser the command (advance or clear). Each item yields exactly one result
// item on the m_ channel with the step count, the dropped ticks and the
// accumulator after the command.
// A clear command or an advance of zero ticks goes from idle straight to the
// output state. A nonzero advance runs a bit-serial division of the summed
// ticks by the step length, one quotient bit per cycle, followed by a
// multiply and a subtract for the dropped time, before the output state.
// The block takes one item at a time; s_tready is high only while it is
// idle, from the cycle after a result is loaded.
// The result waits in an output register, so the next item is accepted while
// an earlier result is still held by a stalled receiver; a finished result
// then waits until the register is free.
// The configuration port is written with cfg_wr_en, cfg_index and cfg_data;
// the user must write it only while the block is idle; the block itself does
// not enforce this. Reset restores the step length to 1000000 ticks, the
// catch-up limit to 8 steps, clears the accumulator and drops any result.
module fixed_step_catch_up_clock_unit
  import fscc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [TIME_W-1:0]      s_tdata,  // elapsed_ticks
  input  logic                   s_tuser,  // command
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,  // step_count, dropped_ticks, accumulator_ticks, zero pad
  input  logic                   cfg_wr_en,
  input  logic                   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_SUB,
    ST_OUT
  } state_t;

  state_t             state;
  logic [TIME_W-1:0]  step_length;
  logic [CATCH_W-1:0] max_catch_up;
  logic [TIME_W-1:0]  accumulator;
  logic [TIME_W-1:0]  divisor;
  logic [DIV_W-1:0]   sum;
  logic               div_start;
  logic               div_done;
  logic [DIV_W-1:0]   div_quo;
  logic [TIME_W-1:0]  div_rem;
  logic [CATCH_W-1:0] issued;
  logic [DIV_W-1:0]   whole;
  logic [PROD_W-1:0]  prod;
  logic [CATCH_W-1:0] res_steps;
  logic [DROP_W-1:0]  res_dropped;
  logic [TIME_W-1:0]  res_acc;
  logic               out_load;

  assign s_tready = (state == ST_IDLE);
  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);

  fscc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (sum),
    .divisor   (divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step_length <= STEP_LENGTH_RESET;
      max_catch_up <= MAX_CATCH_UP_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_STEP_LENGTH:  step_length <= cfg_data[TIME_W-1:0];
        REG_MAX_CATCH_UP: max_catch_up <= cfg_data[CATCH_W-1:0];
        default:          step_length <= step_length;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      accumulator <= '0;
      div_start <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            res_steps <= '0;
            res_dropped <= '0;
            if (s_tuser == CMD_CLEAR) begin
              accumulator <= '0;
              res_acc <= '0;
              state <= ST_OUT;
            end else if (s_tdata == '0) begin
              res_acc <= accumulator;
              state <= ST_OUT;
            end else begin
              sum <= {1'b0, accumulator} + {1'b0, s_tdata};
              divisor <= (step_length == '0) ? TIME_W'(1) : step_length;
              div_start <= 1'b1;
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            issued <= (div_quo > {{(DIV_W-CATCH_W){1'b0}}, max_catch_up}) ?
                      max_catch_up : div_quo[CATCH_W-1:0];
            whole <= sum - {1'b0, div_rem};
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod <= PROD_W'(issued) * PROD_W'(divisor);
          accumulator <= div_rem;
          state <= ST_SUB;
        end
        ST_SUB: begin
          res_dropped <= whole - prod[DROP_W-1:0];
          res_steps <= issued;
          res_acc <= accumulator;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            m_tdata <= {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, res_acc, res_dropped, res_steps};
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
